/* sv/sfc_pkg.sv */
// Shared constants and types of the SysEx frame capture block.
package sfc_pkg;

  localparam int FRAME_DEPTH_DEF         = 128;
  localparam int STATUS_FRAME_LENGTH_DEF = 47;

  localparam logic [7:0] SOX_BYTE        = 8'hF0;
  localparam logic [7:0] EOX_BYTE        = 8'hF7;
  localparam logic [7:0] REQ_ID_BYTE     = 8'h38;
  localparam logic [7:0] RES_ID_BYTE     = 8'h39;
  localparam logic [7:0] STATUS_CMD_BYTE = 8'h03;
  localparam int         REQ_FRAME_LENGTH = 4;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] frame_length;
    logic       frame_ready;
    logic       is_status_request;
    logic       is_status_response;
    logic       rd_hit;
  } sfc_res_t;

endpackage

/* sv/sfc_ram.sv */
// Generic single-port RAM with a registered read.
module sfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* sv/sfc_ctrl.sv */
// Capture control: frame position, held length and store access per request.
module sfc_ctrl
  import sfc_pkg::*;
#(
  parameter int FRAME_DEPTH         = FRAME_DEPTH_DEF,
  parameter int STATUS_FRAME_LENGTH = STATUS_FRAME_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic [1:0]                     req_type,
  input  logic [7:0]                     data_byte,
  input  logic [6:0]                     read_index,
  output logic                           mem_en,
  output logic                           mem_we,
  output logic [$clog2(FRAME_DEPTH)-1:0] mem_addr,
  output logic [7:0]                     mem_wdata,
  output sfc_res_t                       res
);

  localparam int PW = $clog2(FRAME_DEPTH);
  localparam int LW = $clog2(FRAME_DEPTH + 1);
  localparam int IW = (PW > 7) ? PW : 7;
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_DEPTH - 1);

  logic [PW-1:0] wp_r, wp_nxt;
  logic [LW-1:0] hl_r, hl_nxt;
  logic [7:0]    sb_r, sb_nxt;
  logic [7:0]    tb_r, tb_nxt;
  logic [IW-1:0] idx_w;
  logic [1:0]    status;
  logic          rd_hit;

  assign idx_w = IW'(read_index);

  always_comb begin
    wp_nxt    = wp_r;
    hl_nxt    = hl_r;
    sb_nxt    = sb_r;
    tb_nxt    = tb_r;
    status    = ST_OK;
    rd_hit    = 1'b0;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = idx_w[PW-1:0];
    mem_wdata = data_byte;
    if (take) begin
      unique case (req_type)
        REQ_APPEND: begin
          if (hl_r != '0) begin
            status = ST_FULL;
          end else if (data_byte == SOX_BYTE) begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = '0;
            wp_nxt   = PW'(1);
          end else if (wp_r != '0) begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = wp_r;
            if (wp_r == PW'(1)) begin
              sb_nxt = data_byte;
            end
            if (wp_r == PW'(2)) begin
              tb_nxt = data_byte;
            end
            if (data_byte == EOX_BYTE) begin
              hl_nxt = LW'(wp_r) + LW'(1);
              wp_nxt = '0;
              status = ST_DONE;
            end else if (wp_r == LAST_POS) begin
              wp_nxt = '0;
              status = ST_OVERFLOW;
            end else begin
              wp_nxt = wp_r + PW'(1);
            end
          end
        end
        REQ_CLEAR: begin
          wp_nxt = '0;
          hl_nxt = '0;
        end
        REQ_READ: begin
          mem_en = 1'b1;
          rd_hit = 32'(read_index) < 32'(hl_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.status             = status;
    res.frame_length       = 8'(hl_nxt);
    res.frame_ready        = hl_nxt != '0;
    res.is_status_request  = (32'(hl_nxt) == 32'(REQ_FRAME_LENGTH)) &&
                             (sb_nxt == REQ_ID_BYTE) && (tb_nxt == STATUS_CMD_BYTE);
    res.is_status_response = (32'(hl_nxt) == 32'(STATUS_FRAME_LENGTH)) &&
                             (sb_nxt == RES_ID_BYTE) && (tb_nxt == STATUS_CMD_BYTE);
    res.rd_hit             = rd_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      hl_r <= '0;
      sb_r <= '0;
      tb_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      hl_r <= hl_nxt;
      sb_r <= sb_nxt;
      tb_r <= tb_nxt;
    end
  end

  // A held frame and a capture in progress never coexist.
  a_held_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !((hl_r != '0) && (wp_r != '0)))
    else $error("capture in progress while a frame is held");

  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    (hl_r == '0) || (32'(hl_r) >= 2))
    else $error("held frame shorter than start and end bytes");

  a_no_write_held: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (hl_r == '0))
    else $error("store written while a frame is held");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (take && status == ST_DONE) |=> (hl_r != '0) && (wp_r == '0))
    else $error("completed frame not latched");

endmodule

/* sv/sysex_frame_capture.sv */
// Top level of the SysEx frame capture block: handshake stages and frame store.
//
// Requests arrive on the in_ stream, one transaction per request: append a
// stream byte, clear the held frame, or read one stored byte. Every request
// gives exactly one result transaction on the out_ stream, carrying the
// request status, the held frame length and flags, and the read byte.
// A byte 0xF0 restarts capture, 0xF7 closes and holds the frame; while a frame
// is held, appended bytes are dropped until a clear request.
// Throughput is one request per cycle while the receiver keeps up. An accepted
// request's result is registered in the first stage, beside the frame store's
// registered read port, and then in the output register.
// When the receiver stalls, results pile up in the two stages and in_tready
// drops only once both are full; nothing is lost.
// Reset (rst_n low, synchronous) clears the capture position, the held length
// and the pipeline valid bits. The frame store is not cleared: reads are
// limited to the held frame, which always lies in written entries.
module sysex_frame_capture
  import sfc_pkg::*;
#(
  parameter int FRAME_DEPTH         = FRAME_DEPTH_DEF,
  parameter int STATUS_FRAME_LENGTH = STATUS_FRAME_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: data_byte[7:0], read_index[14:8], zero [15].
  input  logic [15:0] in_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: frame_length[7:0], frame_ready[8], is_status_request[9],
  // is_status_response[10], read_data[18:11], zero [23:19].
  output logic [23:0] out_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]  out_tuser
);

  localparam int PW = $clog2(FRAME_DEPTH);

  logic          take;
  logic          s1_adv;
  logic          mem_en, mem_we;
  logic [PW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  sfc_res_t      res;

  logic          s1_v_r, s1_v_nxt;
  sfc_res_t      s1_r;
  logic          out_v_r, out_v_nxt;
  logic [23:0]   out_data_r;
  logic [1:0]    out_user_r;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign take      = in_tvalid && in_tready;

  sfc_ctrl #(
    .FRAME_DEPTH        (FRAME_DEPTH),
    .STATUS_FRAME_LENGTH(STATUS_FRAME_LENGTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .req_type  (in_tuser),
    .data_byte (in_tdata[7:0]),
    .read_index(in_tdata[14:8]),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .res       (res)
  );

  sfc_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= res;
    end
    if (s1_adv) begin
      out_user_r <= s1_r.status;
      out_data_r <= {5'd0,
                     (s1_r.rd_hit ? mem_rdata : 8'd0),
                     s1_r.is_status_response,
                     s1_r.is_status_request,
                     s1_r.frame_ready,
                     s1_r.frame_length};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
